/* rtl/core/kfd_pkg.sv */
// ----------------------------------------------------------------------------
// kfd_pkg
// Shared types and constants of the KISS frame deframer: framing codes and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package kfd_pkg;

  // KISS framing codes
  localparam logic [7:0] CODE_FEND  = 8'hC0;
  localparam logic [7:0] CODE_FESC  = 8'hDB;
  localparam logic [7:0] CODE_TFEND = 8'hDC;
  localparam logic [7:0] CODE_TFESC = 8'hDD;

  // width of the payload limit and of the delivered length
  localparam int unsigned LEN_W = 6;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 6'd63;

  // controller to datapath
  typedef struct packed {
    logic accept;  // input beat taken this cycle
    logic rd_en;   // read the next data byte from the store
    logic load;    // load the output register with the next result
  } kfd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic close_frame;  // current input byte closes a non-empty frame
    logic out_free;     // output register can take a result this cycle
    logic is_last;      // the result about to be loaded ends the run
  } kfd_status_t;

endpackage

/* rtl/core/kfd_ctrl.sv */
// ----------------------------------------------------------------------------
// kfd_ctrl
// Controller of the deframer: takes input bytes while idle and sequences the
// readout of a finished frame from the store into the output register.
// ----------------------------------------------------------------------------
module kfd_ctrl
  import kfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  kfd_status_t status_i,
  output kfd_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_LOAD = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.rd_en  = 1'b0;
    cmd_o.load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.close_frame) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.is_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/kfd_datapath.sv */
// ----------------------------------------------------------------------------
// kfd_datapath
// Datapath of the deframer: escape and frame flags, frame store with fill
// count, payload limit register, readout counter and output register.
// ----------------------------------------------------------------------------
module kfd_datapath
  import kfd_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 64
)(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       rx_byte_i,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  input  logic             out_ready_i,
  input  kfd_cmd_t         cmd_i,
  output kfd_status_t      status_o,
  output logic             out_valid_o,
  output logic [3:0]       port_number_o,
  output logic [3:0]       command_code_o,
  output logic [7:0]       payload_byte_o,
  output logic             has_payload_o,
  output logic [LEN_W-1:0] payload_length_o,
  output logic             last_of_frame_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned FW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CW = LEN_W + 1;

  logic [7:0]       mem [STORE_DEPTH];
  logic [7:0]       rdata_q;
  logic [7:0]       header_q, header_d;
  logic [FW-1:0]    fill_q, fill_d;
  logic             inside_q, inside_d;
  logic             esc_q, esc_d;
  logic [LEN_W-1:0] max_payload_q;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] k_q, k_d;

  logic             out_valid_q;
  logic [3:0]       port_q, cmdc_q;
  logic [7:0]       payload_q;
  logic             has_q, last_q;
  logic [LEN_W-1:0] length_q;

  logic             is_fend, is_fesc, is_tfend, is_tfesc;
  logic             store_req, wr_en;
  logic [7:0]       store_val;
  logic [CW-1:0]    len_raw;
  logic [CW-1:0]    k_next;
  logic [AW-1:0]    rd_addr;

  assign is_fend  = (rx_byte_i == CODE_FEND);
  assign is_fesc  = (rx_byte_i == CODE_FESC);
  assign is_tfend = (rx_byte_i == CODE_TFEND);
  assign is_tfesc = (rx_byte_i == CODE_TFESC);

  // frame length without the port and command byte, clipped to the limit
  assign len_raw = CW'(fill_q) - CW'(1);
  assign k_next  = CW'(k_q) + CW'(1);
  assign rd_addr = k_next[AW-1:0];

  assign status_o.close_frame = is_fend && inside_q && (fill_q != '0);
  assign status_o.out_free    = !out_valid_q || out_ready_i;
  assign status_o.is_last     = (len_q == '0) || (k_next == CW'(len_q));

  always_comb begin
    inside_d  = inside_q;
    esc_d     = esc_q;
    fill_d    = fill_q;
    header_d  = header_q;
    len_d     = len_q;
    k_d       = k_q;
    store_req = 1'b0;
    store_val = rx_byte_i;
    wr_en     = 1'b0;

    if (cmd_i.accept) begin
      if (is_fend) begin
        if (!inside_q) begin
          // opening delimiter keeps a pending escape
          inside_d = 1'b1;
          fill_d   = '0;
        end else begin
          if (fill_q != '0) begin
            len_d = (len_raw > CW'(max_payload_q)) ? max_payload_q : len_raw[LEN_W-1:0];
            k_d   = '0;
          end
          inside_d = 1'b0;
          esc_d    = 1'b0;
          fill_d   = '0;
        end
      end else if (is_fesc) begin
        if (esc_q) begin
          inside_d = 1'b0;
          esc_d    = 1'b0;
          fill_d   = '0;
        end else begin
          esc_d = 1'b1;
        end
      end else if (is_tfend || is_tfesc) begin
        store_req = 1'b1;
        if (esc_q) begin
          store_val = is_tfend ? CODE_FEND : CODE_FESC;
        end
        esc_d = 1'b0;
      end else begin
        if (esc_q) begin
          inside_d = 1'b0;
          esc_d    = 1'b0;
          fill_d   = '0;
        end else begin
          store_req = 1'b1;
        end
      end

      if (store_req) begin
        if (fill_q < FW'(STORE_DEPTH)) begin
          wr_en  = 1'b1;
          fill_d = fill_q + FW'(1);
          if (fill_q == '0) begin
            header_d = store_val;
          end
        end else begin
          // store overflow aborts the frame
          inside_d = 1'b0;
          esc_d    = 1'b0;
          fill_d   = '0;
        end
      end
    end

    if (cmd_i.load) begin
      k_d = k_next[LEN_W-1:0];
    end
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[fill_q[AW-1:0]] <= store_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q      <= 1'b0;
      esc_q         <= 1'b0;
      fill_q        <= '0;
      max_payload_q <= MAX_PAYLOAD_RST;
      out_valid_q   <= 1'b0;
    end else begin
      inside_q <= inside_d;
      esc_q    <= esc_d;
      fill_q   <= fill_d;
      if (cfg_we_i) begin
        max_payload_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    header_q <= header_d;
    len_q    <= len_d;
    k_q      <= k_d;
    if (cmd_i.load) begin
      port_q    <= header_q[7:4];
      cmdc_q    <= header_q[3:0];
      payload_q <= (len_q == '0) ? 8'h00 : rdata_q;
      has_q     <= (len_q != '0);
      length_q  <= len_q;
      last_q    <= status_o.is_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign port_number_o    = port_q;
  assign command_code_o   = cmdc_q;
  assign payload_byte_o   = payload_q;
  assign has_payload_o    = has_q;
  assign payload_length_o = length_q;
  assign last_of_frame_o  = last_q;

endmodule

/* rtl/core/kiss_frame_deframer_core.sv */
// ----------------------------------------------------------------------------
// kiss_frame_deframer_core
// Removes KISS framing from a received byte stream and emits each frame as
// a run of result beats, one per delivered data byte, or a single beat when no data is delivered.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_ready_o, rx_byte_i) takes one stream byte
//   per beat, one beat per cycle while no frame is being read out.
//   a closing FEND on a non-empty frame starts a readout: each result beat
//   reads the frame store once and then loads the output register, so the
//   next read waits for that load to happen; the run holds 1 to 63
//   beats, the last one flagged with last_of_frame_o. the input is not
//   taken during the run, and is taken again while the last beat still waits.
//   after the closing FEND beat the first result goes through ST_READ and ST_LOAD.
//   out_valid_o holds with stable fields while out_ready_i is low; the
//   readout pauses until the output register drains.
//   cfg_we_i / cfg_wdata_i write the payload limit register.
//   reset: no frame open, no pending escape, empty store, limit 63. the
//   store needs no clearing pass; only written entries are ever delivered.
// ----------------------------------------------------------------------------
module kiss_frame_deframer_core
  import kfd_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 64
)(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       rx_byte_i,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [3:0]       port_number_o,
  output logic [3:0]       command_code_o,
  output logic [7:0]       payload_byte_o,
  output logic             has_payload_o,
  output logic [LEN_W-1:0] payload_length_o,
  output logic             last_of_frame_o
);

  kfd_cmd_t    cmd;
  kfd_status_t status;

  kfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kfd_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_byte_i        (rx_byte_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_ready_i      (out_ready_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .port_number_o    (port_number_o),
    .command_code_o   (command_code_o),
    .payload_byte_o   (payload_byte_o),
    .has_payload_o    (has_payload_o),
    .payload_length_o (payload_length_o),
    .last_of_frame_o  (last_of_frame_o)
  );

  // a beat with payload always reports a nonzero length and vice versa
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (has_payload_o == (payload_length_o != '0)))
    else $error("payload flag and length disagree");

  // a frame without data is a single beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_payload_o) |-> last_of_frame_o)
    else $error("empty-payload beat not marked last");

  // no new load into the output register while a beat is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !cmd.load)
    else $error("output register overwritten while stalled");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the KISS frame deframer core. Feeds escaped byte
// streams (clean frames plus aborted, empty and stray sequences), predicts
// each result beat from its own deframer model, and checks every output beat
// in order under several payload limits and sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_top
  import kfd_pkg::*;
;

  localparam int unsigned DEPTH = 64;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [3:0]       port;
    logic [3:0]       cmd;
    logic [7:0]       data;
    logic             has_data;
    logic [LEN_W-1:0] len;
    logic             last;
  } frame_beat_t;

  typedef struct {
    logic [7:0] value;
    bit         hold;
  } rx_item_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       rx_byte = 8'h00;
  logic             cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [3:0]       port_number;
  logic [3:0]       command_code;
  logic [7:0]       payload_byte;
  logic             has_payload;
  logic [LEN_W-1:0] payload_length;
  logic             last_of_frame;

  kiss_frame_deframer_core #(
    .STORE_DEPTH(DEPTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .rx_byte_i       (rx_byte),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .port_number_o   (port_number),
    .command_code_o  (command_code),
    .payload_byte_o  (payload_byte),
    .has_payload_o   (has_payload),
    .payload_length_o(payload_length),
    .last_of_frame_o (last_of_frame)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // deframer model state
  logic [7:0]       frame_buf [DEPTH];
  logic [6:0]       buf_fill = '0;
  logic             frame_open = 1'b0;
  logic             esc_pending = 1'b0;
  logic [LEN_W-1:0] payload_limit = MAX_PAYLOAD_RST;

  frame_beat_t beats_due [$];
  rx_item_t    rx_pending [$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_next = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < 60)
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic clear_frame();
    frame_open  = 1'b0;
    esc_pending = 1'b0;
    buf_fill    = '0;
  endtask

  task automatic store_byte(input logic [7:0] b);
    if (buf_fill < DEPTH) begin
      frame_buf[buf_fill] = b;
      buf_fill = buf_fill + 1'b1;
    end else begin
      clear_frame();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0]  first;
    int          n;
    frame_beat_t beat;
    if (b == CODE_FEND) begin
      if (!frame_open) begin
        // opening delimiter keeps a pending escape
        frame_open = 1'b1;
        buf_fill   = '0;
      end else begin
        if (buf_fill > 0) begin
          first = frame_buf[0];
          n = int'(buf_fill) - 1;
          if (n > int'(payload_limit)) n = int'(payload_limit);
          beat.port = first[7:4];
          beat.cmd  = first[3:0];
          if (n == 0) begin
            beat.data     = 8'h00;
            beat.has_data = 1'b0;
            beat.len      = '0;
            beat.last     = 1'b1;
            beats_due.push_back(beat);
          end else begin
            for (int k = 0; k < n; k++) begin
              beat.data     = frame_buf[k + 1];
              beat.has_data = 1'b1;
              beat.len      = LEN_W'(n);
              beat.last     = (k + 1 == n);
              beats_due.push_back(beat);
            end
          end
        end
        clear_frame();
      end
    end else if (b == CODE_FESC) begin
      if (esc_pending) clear_frame();
      else esc_pending = 1'b1;
    end else if (b == CODE_TFEND || b == CODE_TFESC) begin
      if (esc_pending) begin
        store_byte(b == CODE_TFEND ? CODE_FEND : CODE_FESC);
        esc_pending = 1'b0;
      end else begin
        store_byte(b);
      end
    end else if (esc_pending) begin
      clear_frame();
    end else begin
      store_byte(b);
    end
  endtask

  // driver: next byte goes out once the previous beat is taken
  always @(posedge clk_i) begin
    rx_item_t item;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      // a held byte waits for the bus to go quiet and every due beat to leave
      if (rx_pending.size() > 0 &&
          !(rx_pending[0].hold && (in_valid || beats_due.size() != 0)) &&
          $urandom_range(99) >= send_idle_pct) begin
        item = rx_pending.pop_front();
        in_valid <= 1'b1;
        rx_byte  <= item.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // monitor: predict on input beats, check on output beats
  always @(posedge clk_i) begin
    frame_beat_t want;
    if (rst_ni) begin
      if (in_valid && in_ready) deframe_byte(rx_byte);
      if (out_valid && out_ready) begin
        if (beats_due.size() == 0) begin
          report_mismatch("result beat with none due", payload_byte, 0);
        end else begin
          want = beats_due.pop_front();
          if (port_number !== want.port)
            report_mismatch("port_number", port_number, want.port);
          if (command_code !== want.cmd)
            report_mismatch("command_code", command_code, want.cmd);
          if (payload_byte !== want.data)
            report_mismatch("payload_byte", payload_byte, want.data);
          if (has_payload !== want.has_data)
            report_mismatch("has_payload", has_payload, want.has_data);
          if (payload_length !== want.len)
            report_mismatch("payload_length", payload_length, want.len);
          if (last_of_frame !== want.last)
            report_mismatch("last_of_frame", last_of_frame, want.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycle_count, beats_due.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_raw(input logic [7:0] b);
    rx_item_t item;
    item.value = b;
    item.hold  = hold_next;
    hold_next  = 1'b0;
    rx_pending.push_back(item);
  endtask

  task automatic push_escaped(input logic [7:0] b);
    if (b == CODE_FEND) begin
      push_raw(CODE_FESC);
      push_raw(CODE_TFEND);
    end else if (b == CODE_FESC) begin
      push_raw(CODE_FESC);
      push_raw(CODE_TFESC);
    end else begin
      push_raw(b);
    end
  endtask

  // data byte with a bias toward the framing codes
  function automatic logic [7:0] rand_data();
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0:       return CODE_FEND;
        1:       return CODE_FESC;
        2:       return CODE_TFEND;
        default: return CODE_TFESC;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic push_data(input int n);
    for (int k = 0; k < n; k++) push_escaped(rand_data());
  endtask

  task automatic random_frame();
    int         r;
    int         nd;
    logic [7:0] b;
    r  = $urandom_range(99);
    nd = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 5);
    if (r < 8) begin
      // stray bytes before the frame, dropped by the opening delimiter
      for (int k = $urandom_range(1, 3); k > 0; k--) begin
        b = 8'($urandom_range(255));
        while (b == CODE_FEND || b == CODE_FESC) b = 8'($urandom_range(255));
        push_raw(b);
      end
    end
    if (r >= 8 && r < 14) begin
      // escape left pending across the opening delimiter
      push_raw(CODE_FESC);
      push_raw(CODE_FEND);
      push_raw($urandom_range(1) ? CODE_TFEND : CODE_TFESC);
      push_data(nd);
      push_raw(CODE_FEND);
    end else if (r >= 14 && r < 20) begin
      push_raw(CODE_FEND);
      push_escaped(8'($urandom_range(255)));
      push_data(nd);
      push_raw(CODE_FESC);
      push_raw(CODE_FESC);
      push_data($urandom_range(0, 3));
    end else if (r >= 20 && r < 26) begin
      push_raw(CODE_FEND);
      push_escaped(8'($urandom_range(255)));
      push_data(nd);
      push_raw(CODE_FESC);
      b = 8'($urandom_range(255));
      while (b == CODE_FEND || b == CODE_FESC || b == CODE_TFEND || b == CODE_TFESC)
        b = 8'($urandom_range(255));
      push_raw(b);
    end else if (r >= 26 && r < 31) begin
      push_raw(CODE_FEND);
      push_raw(CODE_FEND);
    end else begin
      push_raw(CODE_FEND);
      push_escaped(8'($urandom_range(255)));
      push_data(nd);
      push_raw(CODE_FEND);
    end
  endtask

  task automatic wait_drained();
    while (rx_pending.size() > 0 || in_valid || beats_due.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_payload_limit(input logic [LEN_W-1:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    payload_limit = v;
  endtask

  initial begin
    logic [LEN_W-1:0] limits [4];
    int               frame_no;
    limits[0] = 6'd63;
    limits[1] = 6'd0;
    limits[2] = 6'd1;
    limits[3] = LEN_W'($urandom_range(2, 62));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      set_payload_limit(limits[phase]);

      if (phase == 0) begin
        // header only, escape cleared by the closing delimiter
        push_raw(CODE_FEND); push_raw(8'h00); push_raw(CODE_FESC); push_raw(CODE_FEND);
        // extreme bytes, both escapes, raw transposed code
        push_raw(CODE_FEND); push_raw(8'hFF); push_raw(8'h00); push_raw(8'hFF);
        push_raw(CODE_FESC); push_raw(CODE_TFEND); push_raw(CODE_FESC); push_raw(CODE_TFESC);
        push_raw(CODE_TFEND); push_raw(CODE_FEND);
        // empty frame
        push_raw(CODE_FEND); push_raw(CODE_FEND);
        // double escape aborts
        push_raw(CODE_FEND); push_raw(8'h12); push_raw(CODE_FESC); push_raw(CODE_FESC);
        // invalid escape aborts
        push_raw(CODE_FEND); push_raw(8'h21); push_raw(CODE_FESC); push_raw(8'h41);
        // stray byte, then an escape carried over the opening delimiter
        push_raw(8'h77); push_raw(CODE_FESC); push_raw(CODE_FEND); push_raw(CODE_TFEND);
        push_raw(8'h99); push_raw(CODE_FEND);
      end

      frame_no = 0;
      if (phase == 0) begin
        // fullest store: header plus 63 data bytes
        push_raw(CODE_FEND);
        push_escaped(8'($urandom_range(255)));
        push_data(DEPTH - 1);
        push_raw(CODE_FEND);
      end
      if (phase == 2) begin
        // one byte past a full store aborts
        push_raw(CODE_FEND);
        push_escaped(8'($urandom_range(255)));
        push_data(DEPTH);
      end
      while (frame_no < 2) begin
        // sender holds off until the outstanding run has drained
        hold_next = (frame_no == 1);
        random_frame();
        frame_no++;
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/kfd_pkg.sv
rtl/core/kfd_ctrl.sv
rtl/core/kfd_datapath.sv
rtl/core/kiss_frame_deframer_core.sv
test/tb_top.sv
